### rtl/ipc_pkg.sv
// Shared types, codes and vector tables for the interrupt priority unit.
`timescale 1ns / 1ps

package ipc_pkg;

  // Source numbering and widths.
  localparam int NUM_SOURCES = 11;
  localparam int SRC_W       = 4;
  localparam int COUNT_W     = 32;
  localparam int RELOAD_W    = 16;
  localparam int CODE_W      = 16;
  localparam int ADDR_W      = 8;
  localparam int IMASK_W     = 8;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 40;

  localparam logic [SRC_W-1:0] SRC_MACHINE = 4'd0;
  localparam logic [SRC_W-1:0] SRC_PROGRAM = 4'd1;
  localparam logic [SRC_W-1:0] SRC_SVC     = 4'd2;
  localparam logic [SRC_W-1:0] SRC_CLK1    = 4'd3;
  localparam logic [SRC_W-1:0] SRC_CLK2    = 4'd4;

  // Interruption code reported for a machine check.
  localparam logic [CODE_W-1:0] MACHINE_CHECK_CODE = 16'h0008;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK1_RELOAD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK2_RELOAD = 1'b1;

  // Item kinds carried on the input tuser.
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_RAISE = 2'd1,
    MODE_LOAD1 = 2'd2,
    MODE_LOAD2 = 2'd3
  } mode_t;

  // One result beat; the first member sits in the highest bits.
  typedef struct packed {
    logic [CODE_W-1:0] interrupt_code;
    logic [ADDR_W-1:0] new_psw_address;
    logic [ADDR_W-1:0] old_psw_address;
    logic [SRC_W-1:0]  served_source;
    logic              unhandled_check;
    logic              taken;
  } result_t;

  // Halfword address where the old PSW of a source is stored.
  function automatic logic [ADDR_W-1:0] vec_old(input logic [SRC_W-1:0] src);
    logic [ADDR_W-1:0] a;
    case (src)
      4'd0:    a = 8'h40;
      4'd1:    a = 8'h48;
      4'd2:    a = 8'h58;
      4'd3:    a = 8'h60;
      4'd4:    a = 8'h68;
      4'd5:    a = 8'h70;
      4'd6:    a = 8'h78;
      4'd7:    a = 8'h80;
      4'd8:    a = 8'h88;
      4'd9:    a = 8'h90;
      4'd10:   a = 8'h98;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Halfword address from which the new PSW of a source is loaded.
  function automatic logic [ADDR_W-1:0] vec_new(input logic [SRC_W-1:0] src);
    logic [ADDR_W-1:0] a;
    case (src)
      4'd0:    a = 8'h44;
      4'd1:    a = 8'h4C;
      4'd2:    a = 8'h5C;
      4'd3:    a = 8'h64;
      4'd4:    a = 8'h6C;
      4'd5:    a = 8'h74;
      4'd6:    a = 8'h7C;
      4'd7:    a = 8'h84;
      4'd8:    a = 8'h8C;
      4'd9:    a = 8'h94;
      4'd10:   a = 8'h9C;
      default: a = '0;
    endcase
    return a;
  endfunction

  // PSW mask bit that enables a source; zero for the sources that the interrupt mask does not gate.
  function automatic logic [IMASK_W-1:0] vec_mask(input logic [SRC_W-1:0] src);
    logic [IMASK_W-1:0] m;
    case (src)
      4'd3:    m = 8'h80;
      4'd4:    m = 8'h40;
      4'd5:    m = 8'h02;
      4'd6:    m = 8'h10;
      4'd7:    m = 8'h08;
      4'd8:    m = 8'h04;
      4'd9:    m = 8'h02;
      4'd10:   m = 8'h01;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

### rtl/interrupt_priority_with_clocks_unit.sv
// Interrupt priority unit with two interval clocks and a registered result stage.
`timescale 1ns / 1ps
// A result beat appears on the master side in the cycle after its item is taken.
// Throughput: one item per cycle; the decrement, underflow test and priority pick all
// sit in one combinational stage between the input beat and the result register.
// The slave side stalls only while a finished result waits on the master side.
// Reset (synchronous, active high) clears pending sources, the stored check code,
// both counters, both reload registers and the result valid flag.

module interrupt_priority_with_clocks_unit (
  input  logic                              clk,
  input  logic                              rst,
  // Input item stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // tdata fields from bit 0: source[3:0], check_code[19:4], counter_value[51:20],
  // interrupt_mask[59:52], machine_check_mask[60], handler_present[61],
  // clock1_enable[62], clock2_enable[63].
  input  logic [ipc_pkg::IN_DATA_W-1:0]     s_tdata,
  // tuser fields from bit 0: mode[1:0].
  input  logic [ipc_pkg::MODE_W-1:0]        s_tuser,
  // Result stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // tdata fields from bit 0: taken[0], unhandled_check[1], served_source[5:2],
  // old_psw_address[13:6], new_psw_address[21:14], interrupt_code[37:22], zeros above.
  output logic [ipc_pkg::OUT_DATA_W-1:0]    m_tdata,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [ipc_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [ipc_pkg::RELOAD_W-1:0]      cfg_data
);

  import ipc_pkg::*;

  // Unpacked input fields.
  mode_t              mode;
  logic [SRC_W-1:0]   source;
  logic [CODE_W-1:0]  check_code;
  logic [COUNT_W-1:0] counter_value;
  logic [IMASK_W-1:0] interrupt_mask;
  logic               machine_check_mask;
  logic               handler_present;
  logic               clock1_enable;
  logic               clock2_enable;

  // State.
  logic [NUM_SOURCES-1:0] pending_flags, pending_flags_next;
  logic [CODE_W-1:0]      stored_check_code, stored_check_code_next;
  logic [COUNT_W-1:0]     clock1_count, clock1_count_next;
  logic [COUNT_W-1:0]     clock2_count, clock2_count_next;
  logic [RELOAD_W-1:0]    clock1_reload;
  logic [RELOAD_W-1:0]    clock2_reload;
  result_t                result, result_next;
  logic                   out_valid;

  // Tick datapath.
  logic [COUNT_W-1:0]     dec1, dec2;
  logic                   under1, under2;
  logic [NUM_SOURCES-1:0] tick_pending;
  logic [NUM_SOURCES-1:0] eligible;
  logic                   found;
  logic [SRC_W-1:0]       sel;
  logic                   accept;

  assign mode               = mode_t'(s_tuser);
  assign source             = s_tdata[3:0];
  assign check_code         = s_tdata[19:4];
  assign counter_value      = s_tdata[51:20];
  assign interrupt_mask     = s_tdata[59:52];
  assign machine_check_mask = s_tdata[60];
  assign handler_present    = s_tdata[61];
  assign clock1_enable      = s_tdata[62];
  assign clock2_enable      = s_tdata[63];

  // The result register frees up when it is empty or being drained.
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, result};

  // Counter decrement and signed underflow test for both clocks.
  always_comb begin
    dec1   = clock1_count - COUNT_W'(1);
    dec2   = clock2_count - COUNT_W'(1);
    under1 = clock1_enable && ((dec1 == '0) || dec1[COUNT_W-1]);
    under2 = clock2_enable && ((dec2 == '0) || dec2[COUNT_W-1]);
    tick_pending = pending_flags;
    tick_pending[SRC_CLK1] = pending_flags[SRC_CLK1] | under1;
    tick_pending[SRC_CLK2] = pending_flags[SRC_CLK2] | under2;
  end

  // Gate each pending source with its enable, then pick the lowest index.
  always_comb begin
    eligible = '0;
    found    = 1'b0;
    sel      = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (SRC_W'(i) == SRC_MACHINE) begin
        eligible[i] = tick_pending[i] && machine_check_mask;
      end else if (SRC_W'(i) == SRC_PROGRAM || SRC_W'(i) == SRC_SVC) begin
        eligible[i] = tick_pending[i];
      end else begin
        eligible[i] = tick_pending[i] && ((interrupt_mask & vec_mask(SRC_W'(i))) != '0);
      end
    end
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (!found && eligible[i]) begin
        found = 1'b1;
        sel   = SRC_W'(i);
      end
    end
  end

  // Next state and result for the item on the slave side.
  always_comb begin
    pending_flags_next     = pending_flags;
    stored_check_code_next = stored_check_code;
    clock1_count_next      = clock1_count;
    clock2_count_next      = clock2_count;
    result_next            = '0;
    unique case (mode)
      MODE_RAISE: begin
        if (source < SRC_W'(NUM_SOURCES)) begin
          pending_flags_next = pending_flags | (NUM_SOURCES'(1) << source);
          if (source == SRC_PROGRAM) begin
            stored_check_code_next = check_code;
          end
        end
      end
      MODE_LOAD1: begin
        clock1_count_next = counter_value;
      end
      MODE_LOAD2: begin
        clock2_count_next = counter_value;
      end
      MODE_TICK: begin
        if (clock1_enable) begin
          clock1_count_next = under1 ? {clock1_reload, {(COUNT_W-RELOAD_W){1'b0}}} : dec1;
        end
        if (clock2_enable) begin
          clock2_count_next = under2 ? {clock2_reload, {(COUNT_W-RELOAD_W){1'b0}}} : dec2;
        end
        pending_flags_next = tick_pending;
        if (found) begin
          pending_flags_next[sel] = 1'b0;
          result_next.served_source = sel;
          if (sel == SRC_PROGRAM) begin
            result_next.interrupt_code = stored_check_code;
          end else if (sel == SRC_MACHINE) begin
            result_next.interrupt_code = MACHINE_CHECK_CODE;
          end
          // A program check with no handler is dropped without a PSW swap.
          if (sel == SRC_PROGRAM && !handler_present) begin
            result_next.unhandled_check = 1'b1;
          end else begin
            result_next.taken           = 1'b1;
            result_next.old_psw_address = vec_old(sel);
            result_next.new_psw_address = vec_new(sel);
          end
        end
      end
      default: ;
    endcase
  end

  // State, configuration and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_flags     <= '0;
      stored_check_code <= '0;
      clock1_count      <= '0;
      clock2_count      <= '0;
      clock1_reload     <= '0;
      clock2_reload     <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_CLOCK1_RELOAD: clock1_reload <= cfg_data;
          CFG_CLOCK2_RELOAD: clock2_reload <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        pending_flags     <= pending_flags_next;
        stored_check_code <= stored_check_code_next;
        clock1_count      <= clock1_count_next;
        clock2_count      <= clock2_count_next;
        out_valid         <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload loads with every accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

### rtl/ipc_checker.sv
// Port-level checks for the interrupt priority unit, bound to its top level.
`timescale 1ns / 1ps

module ipc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [ipc_pkg::OUT_DATA_W-1:0]    m_tdata
);

  import ipc_pkg::*;

  result_t res;
  assign res = result_t'(m_tdata[$bits(result_t)-1:0]);

  // Every accepted item yields a result beat in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("no result beat after an accepted item");

  // A stalled result beat holds its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // A served source either swaps PSWs or is an unhandled program check, never both.
  a_taken_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.taken && res.unhandled_check))
    else $error("taken and unhandled check both set");

  // An unhandled check is always the program check source with no vector addresses.
  a_unhandled_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.unhandled_check |->
      res.served_source == SRC_PROGRAM && res.old_psw_address == '0 &&
      res.new_psw_address == '0)
    else $error("malformed unhandled program check beat");

  // A served machine check reports its fixed interruption code.
  a_machine_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.taken && res.served_source == SRC_MACHINE |->
      res.interrupt_code == MACHINE_CHECK_CODE)
    else $error("machine check served with wrong code");

endmodule

bind interrupt_priority_with_clocks_unit ipc_checker u_ipc_checker (.*);
